// File: sv/ssa_pkg.sv
// ============================================================================
// ssa_pkg: shared types and constants for the spare sector allocator
// Holds the sizes, status and register codes, the controller state type and
// the command and status structs between the controller and the datapath.
// ============================================================================
package ssa_pkg;

    // Sizes of the stores.
    localparam int SPARE_SECTORS = 4096;
    localparam int RING_DEPTH    = 64;
    localparam int SEARCH_LIMIT  = 1000;

    // Derived widths.
    localparam int MAP_AW  = $clog2(SPARE_SECTORS);
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int LOOK_W  = $clog2(SEARCH_LIMIT + 1);
    localparam int CNT_W   = 13;
    localparam int ADDR_W  = 48;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_MARK  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_RING      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFILL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MARK      = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_COUNT = 2'd1;

    // Reset value of spare_count.
    localparam logic [CNT_W-1:0] SPARE_COUNT_RESET = CNT_W'(4096);

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SCAN_START,
        ST_SCAN,
        ST_POP_REFILL,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic do_mark;
        logic pop;
        logic pop_refill;
        logic scan_start;
        logic scan_step;
        logic scan_end;
        logic out_load;
    } ssa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic req_mark;
        logic ring_empty;
        logic scan_more;
        logic out_free;
    } ssa_sts_t;

endpackage

// File: sv/ssa_ctrl.sv
// ============================================================================
// ssa_ctrl: controller of the spare sector allocator
// Sequences the clearing pass, the request decode, the ring pop, the bitmap
// scan that refills the ring, and the hand-off to the output register.
// ============================================================================
module ssa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssa_pkg::ssa_sts_t sts,
    output ssa_pkg::ssa_cmd_t cmd
);

    ssa_pkg::state_t state_reg;
    ssa_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssa_pkg::ST_CLEAR: begin
                if (sts.clear_last) state_next = ssa_pkg::ST_IDLE;
            end
            ssa_pkg::ST_IDLE: begin
                if (s_valid) state_next = ssa_pkg::ST_EXEC;
            end
            ssa_pkg::ST_EXEC: begin
                priority if (sts.req_mark) begin
                    state_next = ssa_pkg::ST_OUT;
                end else if (!sts.ring_empty) begin
                    state_next = ssa_pkg::ST_POP;
                end else begin
                    state_next = ssa_pkg::ST_SCAN_START;
                end
            end
            ssa_pkg::ST_POP: begin
                state_next = ssa_pkg::ST_OUT;
            end
            ssa_pkg::ST_SCAN_START: begin
                state_next = ssa_pkg::ST_SCAN;
            end
            ssa_pkg::ST_SCAN: begin
                // The ring was empty, so an exit with an empty ring means nothing was found.
                if (!sts.scan_more) begin
                    state_next = sts.ring_empty ? ssa_pkg::ST_OUT : ssa_pkg::ST_POP_REFILL;
                end
            end
            ssa_pkg::ST_POP_REFILL: begin
                state_next = ssa_pkg::ST_OUT;
            end
            ssa_pkg::ST_OUT: begin
                if (sts.out_free) state_next = ssa_pkg::ST_IDLE;
            end
            default: begin
                state_next = ssa_pkg::ST_CLEAR;
            end
        endcase
    end

    // Commands.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ssa_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ssa_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ssa_pkg::ST_EXEC: begin
                cmd.do_mark = sts.req_mark;
            end
            ssa_pkg::ST_POP: begin
                cmd.pop = 1'b1;
            end
            ssa_pkg::ST_SCAN_START: begin
                cmd.scan_start = 1'b1;
            end
            ssa_pkg::ST_SCAN: begin
                cmd.scan_step = sts.scan_more;
                cmd.scan_end  = !sts.scan_more;
            end
            ssa_pkg::ST_POP_REFILL: begin
                cmd.pop        = 1'b1;
                cmd.pop_refill = 1'b1;
            end
            ssa_pkg::ST_OUT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/ssa_datapath.sv
// ============================================================================
// ssa_datapath: datapath of the spare sector allocator
// Holds the configuration registers, the reserved-sector bitmap, the ring of
// free indices with its pointers, the scan counters and the result registers.
// ============================================================================
module ssa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_req_type,
    input  logic [ssa_pkg::MAP_AW-1:0]          s_sector_index,
    input  logic                                cfg_valid,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssa_pkg::ADDR_W-1:0]          cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssa_pkg::ADDR_W-1:0]          m_spare_address,
    output logic [ssa_pkg::STAT_W-1:0]          m_alloc_status,
    input  ssa_pkg::ssa_cmd_t                   cmd,
    output ssa_pkg::ssa_sts_t                   sts
);

    // Configuration registers.
    logic [ssa_pkg::ADDR_W-1:0]  base_reg;
    logic [ssa_pkg::CNT_W-1:0]   count_reg;

    // Captured request.
    logic                        req_type_reg;
    logic [ssa_pkg::MAP_AW-1:0]  req_index_reg;

    // Ring pointers and scan state.
    logic [ssa_pkg::RING_AW-1:0] head_reg;
    logic [ssa_pkg::RING_AW-1:0] tail_reg;
    logic [ssa_pkg::FILL_W-1:0]  fill_reg;
    logic [ssa_pkg::CNT_W-1:0]   scan_ptr_reg;
    logic [ssa_pkg::CNT_W-1:0]   cand_reg;
    logic [ssa_pkg::CNT_W-1:0]   cand_next;
    logic [ssa_pkg::LOOK_W-1:0]  looked_reg;
    logic                        found_any_reg;
    logic [ssa_pkg::MAP_AW-1:0]  clr_cnt_reg;
    logic [ssa_pkg::CNT_W-1:0]   scan_stop;

    // Result and output registers.
    logic [ssa_pkg::ADDR_W-1:0]  res_addr_reg;
    logic [ssa_pkg::STAT_W-1:0]  res_status_reg;
    logic                        m_valid_reg;
    logic [ssa_pkg::ADDR_W-1:0]  m_addr_reg;
    logic [ssa_pkg::STAT_W-1:0]  m_status_reg;

    // Memories and their ports.
    logic                        map_mem [ssa_pkg::SPARE_SECTORS];
    logic                        map_rd_reg;
    logic                        map_we;
    logic [ssa_pkg::MAP_AW-1:0]  map_waddr;
    logic                        map_wdata;
    logic [ssa_pkg::MAP_AW-1:0]  ring_mem [ssa_pkg::RING_DEPTH];
    logic [ssa_pkg::MAP_AW-1:0]  ring_rd_reg;
    logic                        ring_we;

    // The scan stops at spare_count, and never beyond the bitmap.
    assign scan_stop = (count_reg > ssa_pkg::CNT_W'(ssa_pkg::SPARE_SECTORS))
                     ? ssa_pkg::CNT_W'(ssa_pkg::SPARE_SECTORS) : count_reg;

    // Status toward the controller.
    assign sts.clear_last = (clr_cnt_reg == {ssa_pkg::MAP_AW{1'b1}});
    assign sts.req_mark   = (req_type_reg == ssa_pkg::REQ_MARK);
    assign sts.ring_empty = (fill_reg == '0);
    assign sts.scan_more  = (fill_reg < ssa_pkg::FILL_W'(ssa_pkg::RING_DEPTH))
                         && (looked_reg < ssa_pkg::LOOK_W'(ssa_pkg::SEARCH_LIMIT))
                         && (cand_reg < scan_stop);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            count_reg <= ssa_pkg::SPARE_COUNT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == ssa_pkg::CFG_SPARE_BASE) begin
                base_reg <= cfg_data;
            end
            if (cfg_index == ssa_pkg::CFG_SPARE_COUNT) begin
                count_reg <= cfg_data[ssa_pkg::CNT_W-1:0];
            end
        end
    end

    // Request capture on an input transaction.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg  <= s_req_type;
            req_index_reg <= s_sector_index;
        end
    end

    // Scan candidate; the bitmap is read one position ahead of the check.
    always_comb begin
        cand_next = cand_reg;
        if (cmd.scan_start) begin
            cand_next = scan_ptr_reg;
        end else if (cmd.scan_step) begin
            cand_next = cand_reg + 1'b1;
        end
    end

    // Bitmap write port: clearing pass, mark, or reservation of a popped index.
    always_comb begin
        map_we    = 1'b0;
        map_waddr = clr_cnt_reg;
        map_wdata = 1'b0;
        priority if (cmd.clear_step) begin
            map_we = 1'b1;
        end else if (cmd.do_mark) begin
            map_we    = 1'b1;
            map_waddr = req_index_reg;
            map_wdata = 1'b1;
        end else if (cmd.pop) begin
            map_we    = 1'b1;
            map_waddr = ring_rd_reg;
            map_wdata = 1'b1;
        end
    end

    // Bitmap memory.
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem[cand_next[ssa_pkg::MAP_AW-1:0]];
    end

    // A clear position seen during the scan goes to the ring tail.
    assign ring_we = cmd.scan_step && !map_rd_reg;

    // Ring memory; the head entry is read every cycle.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[tail_reg] <= cand_reg[ssa_pkg::MAP_AW-1:0];
        end
        ring_rd_reg <= ring_mem[head_reg];
    end

    // Ring pointers, fill count, scan pointer and clearing counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            scan_ptr_reg  <= '0;
            cand_reg      <= '0;
            looked_reg    <= '0;
            found_any_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end else begin
            cand_reg <= cand_next;
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                looked_reg    <= '0;
                found_any_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                looked_reg <= looked_reg + 1'b1;
            end
            if (ring_we) begin
                tail_reg      <= tail_reg + 1'b1;
                fill_reg      <= fill_reg + 1'b1;
                found_any_reg <= 1'b1;
            end
            if (cmd.pop) begin
                head_reg <= head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            // The pointer moves past the scanned range only if something was queued.
            if (cmd.scan_end && found_any_reg) begin
                scan_ptr_reg <= cand_reg;
            end
        end
    end

    // Result of the current request.
    always_ff @(posedge aclk) begin
        if (cmd.do_mark) begin
            res_addr_reg   <= '0;
            res_status_reg <= ssa_pkg::STAT_MARK;
        end else if (cmd.pop) begin
            res_addr_reg   <= base_reg + ssa_pkg::ADDR_W'(ring_rd_reg);
            res_status_reg <= cmd.pop_refill ? ssa_pkg::STAT_REFILL : ssa_pkg::STAT_RING;
        end else if (cmd.scan_end && !found_any_reg) begin
            res_addr_reg   <= '0;
            res_status_reg <= ssa_pkg::STAT_EXHAUSTED;
        end
    end

    // Output register toward the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_spare_address = m_addr_reg;
    assign m_alloc_status  = m_status_reg;

endmodule

// File: sv/spare_sector_allocator.sv
// ============================================================================
// spare_sector_allocator: hands out spare sectors from a reserved bitmap
// A ring of cached free indices serves allocations; an empty ring is refilled
// by a forward scan of the bitmap. Mark requests reserve one sector.
// ============================================================================
// Usage:
// An input transaction on s_ carries a request: allocate (s_req_type 0) or
// mark s_sector_index reserved (s_req_type 1). Every request gives exactly one
// result transaction on m_: the device sector and a status code.
// A mark passes through the states EXEC and OUT before its result is valid,
// and an allocation served from the ring through EXEC, POP and OUT; the
// next request is taken once the block is back in IDLE. An allocation
// that finds the ring empty runs a refill scan that examines one bitmap
// position per cycle, through the single read port of the bitmap memory,
// and at most 1000 positions; its result then passes through POP_REFILL
// and OUT, or goes straight to OUT when nothing is found.
// One request is in flight at a time; s_ready is high only when idle.
// The result sits in an output register, so a stalled receiver holds only
// that register; the next request is still taken and worked on, and waits
// for the register to free before its result is loaded.
// After reset the bitmap is cleared one entry per cycle: s_ready stays low
// until the whole bitmap is clear. Configuration writes on cfg_ are taken at
// any time and must only be issued while the block is idle.
// ============================================================================
module spare_sector_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [11:0]                       s_sector_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [47:0]                       m_spare_address,
    output logic [1:0]                        m_alloc_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [47:0]                       cfg_data
);

    ssa_pkg::ssa_cmd_t cmd;
    ssa_pkg::ssa_sts_t sts;

    // Configuration writes never stall.
    assign cfg_ready = 1'b1;

    // Controller.
    ssa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath.
    ssa_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_sector_index  (s_sector_index),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_spare_address (m_spare_address),
        .m_alloc_status  (m_alloc_status),
        .cmd             (cmd),
        .sts             (sts)
    );

    // Datapath commands that touch state never coincide.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_step, cmd.do_mark, cmd.pop, cmd.scan_step, cmd.scan_end,
                  cmd.scan_start}))
        else $error("overlapping datapath commands");

    // A pop is only issued with a non-empty ring.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !sts.ring_empty)
        else $error("pop from an empty ring");

    // A scan step only happens while the loop condition holds.
    a_scan_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> sts.scan_more)
        else $error("scan step outside the scan range");

    // One request at a time: no acceptance in the cycle after an acceptance.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

endmodule

// File: sim/testbench.sv
// ============================================================================
// testbench: regression for the spare sector allocator
// Drives allocate and mark requests with random bursts and gaps, and random
// stalls on the result side. A scoreboard keeps its own copy of the bitmap,
// the free ring and the scan pointer to predict every result. The run goes
// through several register settings, including an empty spare area, an
// oversized spare count, a window that hits the scan limit and a spare area
// that runs dry.
// ============================================================================
module testbench;

    // One expected result transaction.
    typedef struct packed {
        logic [ssa_pkg::ADDR_W-1:0] address;
        logic [ssa_pkg::STAT_W-1:0] status;
    } alloc_result_t;

    // Predicts allocator results and checks them in order.
    class alloc_scoreboard;
        logic [ssa_pkg::ADDR_W-1:0] base;
        logic [ssa_pkg::CNT_W-1:0]  count;
        bit                         reserved [ssa_pkg::SPARE_SECTORS];
        logic [ssa_pkg::MAP_AW-1:0] ring [ssa_pkg::RING_DEPTH];
        int                         head;
        int                         tail;
        int                         fill;
        int                         scan_ptr;
        int                         failures;
        alloc_result_t              expected_q [$];

        function new();
            base = '0;
            count = ssa_pkg::SPARE_COUNT_RESET;
            foreach (reserved[i]) reserved[i] = 1'b0;
            foreach (ring[i]) ring[i] = '0;
            head = 0;
            tail = 0;
            fill = 0;
            scan_ptr = 0;
            failures = 0;
        endfunction

        function void write_reg(logic [ssa_pkg::CFG_IDX_W-1:0] idx,
                                logic [ssa_pkg::ADDR_W-1:0] data);
            if (idx == ssa_pkg::CFG_SPARE_BASE) begin
                base = data;
            end else if (idx == ssa_pkg::CFG_SPARE_COUNT) begin
                count = data[ssa_pkg::CNT_W-1:0];
            end
        endfunction

        // Forward scan of the bitmap into the free room of the ring.
        function void refill_ring();
            int cand;
            int found;
            int looked;
            int room;
            int stop;
            if (fill >= ssa_pkg::RING_DEPTH / 2) return;
            stop = (count > ssa_pkg::SPARE_SECTORS) ? ssa_pkg::SPARE_SECTORS : int'(count);
            room = ssa_pkg::RING_DEPTH - fill;
            cand = scan_ptr;
            found = 0;
            looked = 0;
            while (found < room && looked < ssa_pkg::SEARCH_LIMIT && cand < stop) begin
                if (!reserved[cand]) begin
                    ring[(tail + found) % ssa_pkg::RING_DEPTH] = ssa_pkg::MAP_AW'(cand);
                    found++;
                end
                cand++;
                looked++;
            end
            tail = (tail + found) % ssa_pkg::RING_DEPTH;
            fill += found;
            if (found > 0) scan_ptr = cand;
        endfunction

        // Takes the ring head, reserves it and forms the device sector.
        function bit pop_ring(output logic [ssa_pkg::ADDR_W-1:0] address);
            logic [ssa_pkg::MAP_AW-1:0] idx;
            address = '0;
            if (fill == 0) return 1'b0;
            idx = ring[head];
            head = (head + 1) % ssa_pkg::RING_DEPTH;
            fill--;
            reserved[idx] = 1'b1;
            address = base + ssa_pkg::ADDR_W'(idx);
            return 1'b1;
        endfunction

        function void note_request(logic req_type, logic [ssa_pkg::MAP_AW-1:0] idx);
            alloc_result_t              r;
            logic [ssa_pkg::ADDR_W-1:0] address;
            r.address = '0;
            if (req_type == ssa_pkg::REQ_MARK) begin
                reserved[idx] = 1'b1;
                r.status = ssa_pkg::STAT_MARK;
            end else if (pop_ring(address)) begin
                r.address = address;
                r.status = ssa_pkg::STAT_RING;
            end else begin
                refill_ring();
                if (pop_ring(address)) begin
                    r.address = address;
                    r.status = ssa_pkg::STAT_REFILL;
                end else begin
                    r.status = ssa_pkg::STAT_EXHAUSTED;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [ssa_pkg::ADDR_W-1:0] address,
                                   logic [ssa_pkg::STAT_W-1:0] status);
            alloc_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: spare_address %h alloc_status %0d",
                       address, status);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (address !== e.address) begin
                $error("spare_address: expected %h, actual %h", e.address, address);
                failures++;
            end
            if (status !== e.status) begin
                $error("alloc_status: expected %0d, actual %0d", e.status, status);
                failures++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_req_type;
    logic [11:0]                   s_sector_index;
    logic                          m_valid;
    logic                          m_ready;
    logic [47:0]                   m_spare_address;
    logic [1:0]                    m_alloc_status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [47:0]                   cfg_data;

    alloc_scoreboard sb = new();
    int              burst_left;
    bit              hold_req;

    spare_sector_allocator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_sector_index  (s_sector_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_spare_address (m_spare_address),
        .m_alloc_status  (m_alloc_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("spare_sector_allocator regression: fail");
        $finish;
    end

    // Result side: checks every transaction and stalls on its own pattern,
    // with one long hold-off on request so the block backs up.
    initial begin
        int run_left;
        int stall_left;
        int hold_left;
        run_left = 0;
        stall_left = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_spare_address, m_alloc_status);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 24);
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                run_left--;
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one request; the sender may idle between bursts of random length.
    task automatic send_req(input logic req_type, input logic [11:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_req_type <= req_type;
        s_sector_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req_type, idx);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic program_regs(input logic [47:0] base,
                                input logic [ssa_pkg::CNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= ssa_pkg::CFG_SPARE_BASE;
        cfg_data <= base;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(ssa_pkg::CFG_SPARE_BASE, base);
        cfg_index <= ssa_pkg::CFG_SPARE_COUNT;
        cfg_data <= {{(48 - ssa_pkg::CNT_W){1'b0}}, count};
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(ssa_pkg::CFG_SPARE_COUNT, {{(48 - ssa_pkg::CNT_W){1'b0}}, count});
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_base();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom();
        lo = $urandom();
        return {hi[15:0], lo};
    endfunction

    // Mostly allocations; marks land anywhere or just ahead of the scan.
    task automatic run_random(input int n, input int mark_pct);
        int          p;
        logic [11:0] idx;
        for (int i = 0; i < n; i++) begin
            idx = 12'($urandom());
            if ($urandom_range(0, 99) < mark_pct) begin
                if ($urandom_range(0, 3) == 0) begin
                    p = sb.scan_ptr + $urandom_range(0, 80);
                    if (p > ssa_pkg::SPARE_SECTORS - 1) p = ssa_pkg::SPARE_SECTORS - 1;
                    idx = 12'(p);
                end
                send_req(ssa_pkg::REQ_MARK, idx);
            end else begin
                send_req(ssa_pkg::REQ_ALLOC, idx);
            end
        end
    endtask

    // Reserves almost the whole search window ahead of the scan pointer, so
    // the next refill runs out of search budget with few entries found.
    task automatic reserve_window();
        int first;
        int last;
        first = sb.scan_ptr;
        last = first + ssa_pkg::SEARCH_LIMIT;
        if (last > ssa_pkg::SPARE_SECTORS) last = ssa_pkg::SPARE_SECTORS;
        for (int p = first; p < last; p++) begin
            if ($urandom_range(0, 127) != 0) send_req(ssa_pkg::REQ_MARK, 12'(p));
        end
    endtask

    // Main sequence.
    initial begin
        int lim;
        s_valid <= 1'b0;
        s_req_type <= ssa_pkg::REQ_ALLOC;
        s_sector_index <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ssa_pkg::CFG_SPARE_BASE;
        cfg_data <= '0;
        aresetn <= 1'b0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first refill, a ring hit, marks at the index extremes,
        // a mark on an index already queued in the ring (handed out anyway),
        // a mark on one already reserved, and one ahead of the scan.
        send_req(ssa_pkg::REQ_ALLOC, 12'hFFF);
        send_req(ssa_pkg::REQ_ALLOC, 12'h000);
        send_req(ssa_pkg::REQ_MARK, 12'd5);
        send_req(ssa_pkg::REQ_MARK, 12'hFFF);
        send_req(ssa_pkg::REQ_MARK, 12'h000);
        send_req(ssa_pkg::REQ_MARK, 12'd100);
        send_req(ssa_pkg::REQ_ALLOC, 12'h555);
        send_req(ssa_pkg::REQ_ALLOC, 12'hAAA);
        send_req(ssa_pkg::REQ_ALLOC, 12'h000);
        send_req(ssa_pkg::REQ_ALLOC, 12'hFFF);
        send_req(ssa_pkg::REQ_MARK, 12'hAAA);
        send_req(ssa_pkg::REQ_MARK, 12'h555);
        drain();

        // Empty spare area at the top of the address space: the ring still
        // serves what it holds, with addresses that wrap around.
        program_regs(48'hFFFF_FFFF_FFFF, '0);
        run_random(50, 20);
        drain();

        // Oversized spare count, with a long result stall midway.
        program_regs(rand_base(), {ssa_pkg::CNT_W{1'b1}});
        run_random(50, 25);
        hold_req = 1'b1;
        run_random(50, 25);
        drain();

        // Scan limit reached within a mostly reserved window.
        program_regs(rand_base(), ssa_pkg::SPARE_COUNT_RESET);
        reserve_window();
        run_random(80, 10);
        drain();

        // Spare area ends just past the scan pointer and runs dry.
        lim = sb.scan_ptr + $urandom_range(1, 120);
        if (lim > ssa_pkg::SPARE_SECTORS) lim = ssa_pkg::SPARE_SECTORS;
        program_regs(rand_base(), ssa_pkg::CNT_W'(lim));
        run_random(100, 15);
        drain();

        // Zero base with the full spare area.
        program_regs('0, ssa_pkg::SPARE_COUNT_RESET);
        run_random(30, 30);
        drain();

        if (sb.failures == 0) begin
            $display("spare_sector_allocator regression: pass");
        end else begin
            $display("spare_sector_allocator regression: fail");
        end
        $finish;
    end
endmodule
